FILE: rtl/cpr_pkg.sv
// Shared types and constants for the controller poll responder.
`timescale 1ns / 1ps

package cpr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned BTN_W      = 16;
    localparam int unsigned RESP_MAX   = 10;
    localparam int unsigned RESP_CNT_W = $clog2(RESP_MAX + 1);
    localparam int unsigned ARG_MAX    = 4;
    localparam int unsigned ARG_IDX_W  = $clog2(ARG_MAX);
    localparam int unsigned ARGS_W     = 3;
    localparam int unsigned APB_AW     = 3;
    localparam int unsigned APB_DW     = 32;

    typedef logic [BYTE_W-1:0] byte_t;

    // Command codes seen on the bus.
    localparam byte_t CMD_ID       = 8'h00;
    localparam byte_t CMD_RESET    = 8'hFF;
    localparam byte_t CMD_POLL     = 8'h40;
    localparam byte_t CMD_ORIGIN   = 8'h41;
    localparam byte_t CMD_CALIB    = 8'h42;
    localparam byte_t CMD_LONG     = 8'h43;
    localparam byte_t CMD_VERSION  = 8'h44;
    localparam byte_t CMD_UPDATE   = 8'h45;

    // Response bytes and report fill values.
    localparam byte_t ID_BYTE0     = 8'h09;
    localparam byte_t ID_BYTE2     = 8'h03;
    localparam byte_t UPD_REJECT   = 8'h01;
    localparam byte_t ORIGIN_BTN   = 8'h80;
    localparam byte_t STICK_CENTER = 8'h7F;
    localparam byte_t NIBBLE_MASK  = 8'hF0;

    // Poll report packing modes.
    localparam logic [2:0] MODE_STD    = 3'd0;
    localparam logic [2:0] MODE_1      = 3'd1;
    localparam logic [2:0] MODE_2      = 3'd2;
    localparam logic [2:0] MODE_3      = 3'd3;
    localparam logic [2:0] MODE_4      = 3'd4;
    localparam logic [2:0] MODE_FULL   = 3'd5;
    localparam logic [2:0] MODE_ORIGIN = 3'd6;
    localparam byte_t      MODE_TOP    = 8'h04;

    // Configuration register indexes.
    localparam logic CFG_MAX_UPDATE = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    localparam logic [31:0] MAX_UPDATE_RST = 32'd2093056;
    localparam byte_t       TIMEOUT_RST    = 8'd48;

    // One input transaction.
    typedef struct packed {
        logic        cmd;
        byte_t       rx_byte;
        logic [15:0] buttons;
        byte_t       lstick_x;
        byte_t       lstick_y;
        byte_t       rstick_x;
        byte_t       rstick_y;
        byte_t       ltrig;
        byte_t       rtrig;
    } in_item_t;

    // A complete response run before it is shifted out.
    typedef struct packed {
        logic [RESP_MAX-1:0][BYTE_W-1:0] bytes;
        logic [RESP_CNT_W-1:0]           len;
        logic                            upd;
        logic                            org;
    } resp_t;

    localparam logic cmd_byte = 1'b0;

endpackage

FILE: rtl/cpr_in_if.sv
// Input channel interface: received bytes, ticks and controller state.
`timescale 1ns / 1ps

interface cpr_in_if;
    import cpr_pkg::*;

    logic        valid;
    logic        ready;
    logic        cmd;
    byte_t       rx_byte;
    logic [15:0] buttons;
    byte_t       lstick_x;
    byte_t       lstick_y;
    byte_t       rstick_x;
    byte_t       rstick_y;
    byte_t       ltrig;
    byte_t       rtrig;

    modport source (
        output valid, cmd, rx_byte, buttons, lstick_x, lstick_y,
               rstick_x, rstick_y, ltrig, rtrig,
        input  ready
    );

    modport sink (
        input  valid, cmd, rx_byte, buttons, lstick_x, lstick_y,
               rstick_x, rstick_y, ltrig, rtrig,
        output ready
    );
endinterface

FILE: rtl/cpr_out_if.sv
// Output channel interface: response bytes with run markers.
`timescale 1ns / 1ps

interface cpr_out_if;
    import cpr_pkg::*;

    logic  valid;
    logic  ready;
    byte_t tx_byte;
    logic  last_byte;
    logic  enter_update;
    logic  clear_origin;

    modport source (
        output valid, tx_byte, last_byte, enter_update, clear_origin,
        input  ready
    );

    modport sink (
        input  valid, tx_byte, last_byte, enter_update, clear_origin,
        output ready
    );
endinterface

FILE: rtl/controller_poll_responder_unit.sv
// Top level of the controller poll responder: request decoder and response shifter.
`timescale 1ns / 1ps

// Device side of a game-controller serial bus.
//
// in_ch carries one transaction per received bus byte (cmd = 0) or per time
// tick (cmd = 1), together with the current button, stick and trigger state.
// out_ch delivers the response as a run of byte transactions; last_byte marks
// the final byte of a run, and enter_update / clear_origin ride on that byte.
//
// An accepted transaction lands in an input register. When the output side is free
// it is decoded against the request state and, when it completes a request, the
// whole response (1, 3, 8 or 10 bytes) is loaded into a shift buffer, whose
// register offers the first response byte. The buffer then emits one byte per
// cycle while the receiver is ready. Transactions that produce no response pass
// at one per cycle while the buffer is free; a request's run holds the output
// side, and the next transaction is decoded in the cycle its last byte goes.
//
// If the receiver stalls, the buffer holds its bytes and the input register
// keeps one further transaction before in_ch.ready drops. Reset clears the
// request state, empties both stages and loads the configuration defaults
// (maximum update size 2093056, timeout 48 ticks). Configuration is written
// over the APB port; registers sit at byte addresses 0 and 4.
module controller_poll_responder_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    cpr_in_if.sink                       in_ch,
    cpr_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpr_pkg::APB_AW-1:0]   paddr,
    input  logic [cpr_pkg::APB_DW-1:0]   pwdata,
    output logic [cpr_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import cpr_pkg::*;

    // Number of argument bytes that follow a command byte.
    function automatic logic [ARGS_W-1:0] arg_count(input byte_t c);
        logic [ARGS_W-1:0] n;
        n = '0;
        if (c == CMD_POLL || c == CMD_CALIB || c == CMD_LONG)
        begin
            n = ARGS_W'(2);
        end
        else if (c == CMD_UPDATE)
        begin
            n = ARGS_W'(4);
        end
        return n;
    endfunction

    // High nibble of one value and high nibble of another in one byte.
    function automatic byte_t pack_nib(input byte_t hi, input byte_t lo);
        return (hi & NIBBLE_MASK) | (lo >> 4);
    endfunction

    // Builds a poll report in the given packing mode.
    function automatic resp_t poll_report(input logic [2:0] mode, input in_item_t it,
                                          input logic org);
        resp_t r;
        r       = '0;
        r.len   = RESP_CNT_W'(8);
        r.org   = org;
        if (mode == MODE_ORIGIN)
        begin
            r.bytes[1] = ORIGIN_BTN;
            r.bytes[2] = STICK_CENTER;
            r.bytes[3] = STICK_CENTER;
            r.bytes[4] = STICK_CENTER;
            r.bytes[5] = STICK_CENTER;
            r.len      = RESP_CNT_W'(RESP_MAX);
        end
        else
        begin
            r.bytes[0] = it.buttons[15:8];
            r.bytes[1] = it.buttons[7:0];
            r.bytes[2] = it.lstick_x;
            r.bytes[3] = it.lstick_y;
            case (mode)
                MODE_STD:
                begin
                    r.bytes[4] = it.rstick_x;
                    r.bytes[5] = it.rstick_y;
                    r.bytes[6] = pack_nib(it.ltrig, it.rtrig);
                end
                MODE_1:
                begin
                    r.bytes[4] = pack_nib(it.rstick_x, it.rstick_y);
                    r.bytes[5] = it.ltrig;
                    r.bytes[6] = it.rtrig;
                end
                MODE_2:
                begin
                    r.bytes[4] = pack_nib(it.rstick_x, it.rstick_y);
                    r.bytes[5] = pack_nib(it.ltrig, it.rtrig);
                end
                MODE_3:
                begin
                    r.bytes[4] = it.rstick_x;
                    r.bytes[5] = it.rstick_y;
                    r.bytes[6] = it.ltrig;
                    r.bytes[7] = it.rtrig;
                end
                MODE_4:
                begin
                    r.bytes[4] = it.rstick_x;
                    r.bytes[5] = it.rstick_y;
                end
                default:
                begin
                    r.bytes[4] = it.rstick_x;
                    r.bytes[5] = it.rstick_y;
                    r.bytes[6] = it.ltrig;
                    r.bytes[7] = it.rtrig;
                    r.len      = RESP_CNT_W'(RESP_MAX);
                end
            endcase
        end
        return r;
    endfunction

    // Configuration registers.
    logic [31:0] max_update_reg;
    byte_t       timeout_reg;
    logic        cfg_wr;

    // Input stage.
    in_item_t    in_item_reg;
    logic        in_vld_reg;
    logic        in_vld_next;

    // Request state.
    logic              busy_reg,    busy_next;
    byte_t             pend_reg,    pend_next;
    logic [ARGS_W-1:0] left_reg,    left_next;
    byte_t             gap_reg,     gap_next;
    byte_t             arg_reg [ARG_MAX];
    byte_t             arg_view [ARG_MAX];
    logic              arg_wr;
    logic [ARG_IDX_W-1:0] arg_idx;
    logic [ARGS_W-1:0] n_new;
    logic [ARGS_W-1:0] n_pend;
    logic [ARGS_W-1:0] idx_full;

    // Response shift buffer.
    logic [RESP_MAX-1:0][BYTE_W-1:0] buf_reg, buf_next;
    logic [RESP_CNT_W-1:0]           cnt_reg, cnt_next;
    logic                            upd_reg, upd_next;
    logic                            org_reg, org_next;

    logic        pop;
    logic        buf_free;
    logic        proc;
    logic        fin;
    byte_t       fcmd;
    resp_t       resp;
    logic [31:0] upd_size;
    logic [2:0]  poll_mode;

    // ------------------------------------------------------------------
    // APB configuration port. Writes complete in the access phase; the
    // register is selected by address bit 2.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_update_reg <= MAX_UPDATE_RST;
            timeout_reg    <= TIMEOUT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                CFG_MAX_UPDATE: max_update_reg <= pwdata[31:0];
                CFG_TIMEOUT:    timeout_reg    <= pwdata[BYTE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            CFG_MAX_UPDATE: prdata = max_update_reg;
            CFG_TIMEOUT:    prdata = {{(APB_DW-BYTE_W){1'b0}}, timeout_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes. The decode stage fires when the buffer is empty or its
    // final byte leaves in this cycle, so runs follow each other without
    // a gap.
    // ------------------------------------------------------------------
    assign pop      = out_ch.valid & out_ch.ready;
    assign buf_free = (cnt_reg == '0) || (cnt_reg == RESP_CNT_W'(1) && out_ch.ready);
    assign proc     = in_vld_reg & buf_free;
    assign in_ch.ready = ~in_vld_reg | buf_free;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_ch.valid && in_ch.ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (proc)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg.cmd      <= in_ch.cmd;
            in_item_reg.rx_byte  <= in_ch.rx_byte;
            in_item_reg.buttons  <= in_ch.buttons;
            in_item_reg.lstick_x <= in_ch.lstick_x;
            in_item_reg.lstick_y <= in_ch.lstick_y;
            in_item_reg.rstick_x <= in_ch.rstick_x;
            in_item_reg.rstick_y <= in_ch.rstick_y;
            in_item_reg.ltrig    <= in_ch.ltrig;
            in_item_reg.rtrig    <= in_ch.rtrig;
        end
    end

    // ------------------------------------------------------------------
    // Request decode. A byte while idle is a command; a byte while busy is
    // an argument. A tick while busy either counts the gap or, once the gap
    // has reached the timeout, drops the request without a response.
    // ------------------------------------------------------------------
    assign n_new    = arg_count(in_item_reg.rx_byte);
    assign n_pend   = arg_count(pend_reg);
    assign idx_full = n_pend - left_reg;
    assign arg_idx  = idx_full[ARG_IDX_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        pend_next = pend_reg;
        left_next = left_reg;
        gap_next  = gap_reg;
        arg_wr    = 1'b0;
        fin       = 1'b0;
        fcmd      = in_item_reg.rx_byte;
        if (proc)
        begin
            if (in_item_reg.cmd != cmd_byte)
            begin
                if (busy_reg)
                begin
                    if (gap_reg >= timeout_reg)
                    begin
                        busy_next = 1'b0;
                        left_next = '0;
                        gap_next  = '0;
                    end
                    else
                    begin
                        gap_next = gap_reg + 8'd1;
                    end
                end
            end
            else if (!busy_reg)
            begin
                if (n_new == '0)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    busy_next = 1'b1;
                    pend_next = in_item_reg.rx_byte;
                    left_next = n_new;
                    gap_next  = '0;
                end
            end
            else
            begin
                arg_wr    = 1'b1;
                left_next = left_reg - ARGS_W'(1);
                gap_next  = '0;
                if (left_reg == ARGS_W'(1))
                begin
                    busy_next = 1'b0;
                    fin       = 1'b1;
                    fcmd      = pend_reg;
                end
            end
        end
    end

    // Argument bytes as they will stand after this cycle's write, so the
    // final argument of a request is visible to its own response.
    always_comb
    begin
        for (int i = 0; i < ARG_MAX; i++)
        begin
            arg_view[i] = (arg_wr && arg_idx == ARG_IDX_W'(i)) ? in_item_reg.rx_byte
                                                                : arg_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (arg_wr)
        begin
            arg_reg[arg_idx] <= in_item_reg.rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Response build for the command that completes in this cycle.
    // ------------------------------------------------------------------
    assign upd_size  = {arg_view[3], arg_view[2], arg_view[1], arg_view[0]};
    assign poll_mode = (arg_view[0] > MODE_TOP) ? MODE_STD : arg_view[0][2:0];

    always_comb
    begin
        resp = '0;
        if (fin)
        begin
            case (fcmd)
                CMD_ID, CMD_RESET:
                begin
                    resp.bytes[0] = ID_BYTE0;
                    resp.bytes[2] = ID_BYTE2;
                    resp.len      = RESP_CNT_W'(3);
                end
                CMD_VERSION:
                begin
                    resp.len = RESP_CNT_W'(3);
                end
                CMD_UPDATE:
                begin
                    resp.len = RESP_CNT_W'(1);
                    if (upd_size <= max_update_reg)
                    begin
                        resp.upd = 1'b1;
                    end
                    else
                    begin
                        resp.bytes[0] = UPD_REJECT;
                    end
                end
                CMD_POLL:
                begin
                    resp = poll_report(poll_mode, in_item_reg, 1'b0);
                end
                CMD_ORIGIN:
                begin
                    resp = poll_report(MODE_ORIGIN, in_item_reg, 1'b1);
                end
                CMD_CALIB, CMD_LONG:
                begin
                    resp = poll_report(MODE_FULL, in_item_reg, 1'b0);
                end
                default:
                begin
                    resp = '0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Response shift buffer: byte 0 is on the output; each transaction
    // moves the run down by one byte.
    // ------------------------------------------------------------------
    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        upd_next = upd_reg;
        org_next = org_reg;
        if (pop)
        begin
            buf_next = buf_reg >> BYTE_W;
            cnt_next = cnt_reg - RESP_CNT_W'(1);
        end
        if (resp.len != '0)
        begin
            buf_next = resp.bytes;
            cnt_next = resp.len;
            upd_next = resp.upd;
            org_next = resp.org;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        upd_reg <= upd_next;
        org_reg <= org_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            busy_reg   <= 1'b0;
            pend_reg   <= '0;
            left_reg   <= '0;
            gap_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            busy_reg   <= busy_next;
            pend_reg   <= pend_next;
            left_reg   <= left_next;
            gap_reg    <= gap_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign out_ch.valid        = (cnt_reg != '0);
    assign out_ch.tx_byte      = buf_reg[0];
    assign out_ch.last_byte    = (cnt_reg == RESP_CNT_W'(1));
    assign out_ch.enter_update = upd_reg & (cnt_reg == RESP_CNT_W'(1));
    assign out_ch.clear_origin = org_reg & (cnt_reg == RESP_CNT_W'(1));

endmodule
